@@ rtl/ett_pkg.sv @@
// Shared types and constants for the event timeout timer bank.
`default_nettype none

package ett_pkg;

  localparam int unsigned EVENT_COUNT_DEF = 8;
  localparam int unsigned TIMER_WIDTH_DEF = 32;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned FLAGS_W   = 8;

  localparam int unsigned IN_DATA_W  = MASK_W + TIMEOUT_W;
  localparam int unsigned OUT_DATA_W = 2 * FLAGS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ARM   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TICK  = 2'd3
  } ett_op_e;

  typedef struct packed {
    ett_op_e                op;
    logic [MASK_W-1:0]      mask;
    logic [TIMEOUT_W-1:0]   timeout;
  } ett_cmd_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] pending;
    logic [FLAGS_W-1:0] expired;
  } ett_res_t;

endpackage

`default_nettype wire

@@ rtl/ett_timer_bank.sv @@
// Countdown timers and pending flags, updated once per command.
`default_nettype none

module ett_timer_bank
  import ett_pkg::*;
#(
  parameter int unsigned EVENT_COUNT = EVENT_COUNT_DEF,
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     upd_i,
  input  wire ett_cmd_t cmd_i,
  output ett_res_t      res_o
);

  logic [TIMER_WIDTH-1:0] cnt_q [EVENT_COUNT];
  logic [TIMER_WIDTH-1:0] cnt_d [EVENT_COUNT];
  logic [EVENT_COUNT-1:0] flags_q, flags_d;
  logic [EVENT_COUNT-1:0] m;
  logic [EVENT_COUNT-1:0] exp_w;
  logic                   load_ok;
  logic [63:0]            t64, tmax64, sat64;
  logic [TIMER_WIDTH-1:0] load_val;

  for (genvar i = 0; i < EVENT_COUNT; i++) begin : g_mask
    if (i < MASK_W) begin : g_in
      assign m[i] = cmd_i.mask[i];
    end else begin : g_out
      assign m[i] = 1'b0;
    end
  end

  // saturate the load at the timer's largest value
  assign t64      = {{(64-TIMEOUT_W){1'b0}}, cmd_i.timeout};
  assign tmax64   = {64{1'b1}} >> (64 - TIMER_WIDTH);
  assign sat64    = (t64 > tmax64) ? tmax64 : t64;
  assign load_val = sat64[TIMER_WIDTH-1:0];
  assign load_ok  = (cmd_i.timeout != '0) && (m != '0) &&
                    ((m & (m - EVENT_COUNT'(1))) == '0);

  always_comb begin
    flags_d = flags_q;
    exp_w   = '0;
    for (int i = 0; i < EVENT_COUNT; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    unique case (cmd_i.op)
      OP_ARM: begin
        flags_d = flags_q & ~m;
        for (int i = 0; i < EVENT_COUNT; i++) begin
          if (load_ok && m[i]) cnt_d[i] = load_val;
        end
      end
      OP_SET: begin
        flags_d = flags_q | m;
        for (int i = 0; i < EVENT_COUNT; i++) begin
          if (m[i]) cnt_d[i] = '0;
        end
      end
      OP_CLEAR: begin
        flags_d = flags_q & ~m;
        for (int i = 0; i < EVENT_COUNT; i++) begin
          if (m[i]) cnt_d[i] = '0;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < EVENT_COUNT; i++) begin
          if (cnt_q[i] != '0) begin
            cnt_d[i] = cnt_q[i] - TIMER_WIDTH'(1);
            exp_w[i] = (cnt_q[i] == TIMER_WIDTH'(1));
          end
        end
        flags_d = flags_q | exp_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      for (int i = 0; i < EVENT_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_i) begin
      flags_q <= flags_d;
      for (int i = 0; i < EVENT_COUNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // report the low flag bits, zero above the bank
  for (genvar i = 0; i < FLAGS_W; i++) begin : g_res
    if (i < EVENT_COUNT) begin : g_in
      assign res_o.pending[i] = flags_d[i];
      assign res_o.expired[i] = exp_w[i];
    end else begin : g_out
      assign res_o.pending[i] = 1'b0;
      assign res_o.expired[i] = 1'b0;
    end
  end

  a_tick_raises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && cmd_i.op == OP_TICK |=> ((flags_q & $past(exp_w)) == $past(exp_w)))
    else $error("expired timer did not raise its flag");

  a_clear_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && cmd_i.op == OP_CLEAR |=> ((flags_q & $past(m)) == '0))
    else $error("clear left a named flag set");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(flags_q))
    else $error("flags changed without a command");

endmodule

`default_nettype wire

@@ rtl/event_timeout_timers.sv @@
// Top level of the event timeout timer bank: input register, timer bank, result register.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: mask, timeout; tuser: opcode
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: pending flags, expired bits
//
// One item per cycle sustained while m_axis_tready is high; m_axis shows the result register.
// All timers update in parallel in the bank between the input and result registers.
// Reset zeroes every timer and all flags; no fill or clearing pass is needed.
// A stalled result register holds the input register, which stalls s_axis_tready.
`default_nettype none

module event_timeout_timers
  import ett_pkg::*;
#(
  parameter int unsigned EVENT_COUNT = EVENT_COUNT_DEF,
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // event_mask[7:0], timeout_ticks[39:8]
  input  wire logic [OPCODE_W-1:0]   s_axis_tuser,   // opcode[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // pending_flags[7:0], expired_now[15:8]
);

  logic     in_valid_q;
  ett_cmd_t in_cmd_q;
  logic     out_valid_q;
  ett_res_t out_res_q;
  ett_res_t res_w;
  logic     adv;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q.op      <= ett_op_e'(s_axis_tuser);
      in_cmd_q.mask    <= s_axis_tdata[MASK_W-1:0];
      in_cmd_q.timeout <= s_axis_tdata[IN_DATA_W-1:MASK_W];
    end
  end

  ett_timer_bank #(
    .EVENT_COUNT (EVENT_COUNT),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (in_valid_q && adv),
    .cmd_i  (in_cmd_q),
    .res_o  (res_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      out_res_q <= res_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.expired, out_res_q.pending};

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q)
    else $error("queued item dropped while result stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

@@ test/event_timeout_timers_tb.sv @@
// Self-checking testbench for the event timeout timer bank: directed and random items.
`default_nettype none

module event_timeout_timers_tb
  import ett_pkg::*;
;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned RX_HOLD_CYCLES = 100;

  class timer_scoreboard;
    logic [TIMEOUT_W-1:0] countdown [EVENT_COUNT_DEF];
    logic [FLAGS_W-1:0]   flags;
    ett_res_t             expected_status_q [$];
    int unsigned          mismatches;

    function new();
      for (int i = 0; i < EVENT_COUNT_DEF; i++) countdown[i] = '0;
      flags = '0;
      mismatches = 0;
    endfunction

    // advance the timer bank by one accepted item and queue its status
    function void record_cmd(ett_op_e op, logic [MASK_W-1:0] mask, logic [TIMEOUT_W-1:0] tmo);
      ett_res_t            status;
      logic [FLAGS_W-1:0]  fired;
      bit                  one_hot;
      fired = '0;
      one_hot = (mask != 0) && ((mask & (mask - 8'd1)) == 8'd0);
      case (op)
        OP_ARM: begin
          flags &= ~mask;
          if (tmo != 0 && one_hot) begin
            for (int i = 0; i < EVENT_COUNT_DEF; i++) if (mask[i]) countdown[i] = tmo;
          end
        end
        OP_SET: begin
          for (int i = 0; i < EVENT_COUNT_DEF; i++) if (mask[i]) countdown[i] = '0;
          flags |= mask;
        end
        OP_CLEAR: begin
          for (int i = 0; i < EVENT_COUNT_DEF; i++) if (mask[i]) countdown[i] = '0;
          flags &= ~mask;
        end
        default: begin
          for (int i = 0; i < EVENT_COUNT_DEF; i++) begin
            if (countdown[i] != 0) begin
              countdown[i] = countdown[i] - 1'b1;
              if (countdown[i] == 0) fired[i] = 1'b1;
            end
          end
          flags |= fired;
        end
      endcase
      status.pending = flags;
      status.expired = fired;
      expected_status_q.push_back(status);
    endfunction

    function void check_status(logic [FLAGS_W-1:0] pending, logic [FLAGS_W-1:0] expired);
      ett_res_t exp_status;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pending %h expired %h", pending, expired);
        return;
      end
      exp_status = expected_status_q.pop_front();
      if (pending !== exp_status.pending || expired !== exp_status.expired) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pending exp %h got %h, expired exp %h got %h",
                   exp_status.pending, pending, exp_status.expired, expired);
      end
    endfunction

    function int unsigned outstanding();
      return expected_status_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OPCODE_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  timer_scoreboard sb = new();
  int unsigned     idle_cycles = 0;
  int unsigned     burst_left = 0;
  int unsigned     rx_hold_reqs = 0;

  event_timeout_timers dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_status(m_axis_tdata[7:0], m_axis_tdata[15:8]);
      if (s_axis_tvalid && s_axis_tready)
        sb.record_cmd(ett_op_e'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int unsigned rx_mode;
    int unsigned rx_mode_left;
    int unsigned rx_hold_served;
    rx_mode = 0;
    rx_mode_left = 0;
    rx_hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_served != rx_hold_reqs) begin
        rx_hold_served = rx_hold_reqs;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(10, 60);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic issue(ett_op_e op, logic [MASK_W-1:0] mask, logic [TIMEOUT_W-1:0] tmo);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tmo, mask};
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic random_cmd(output ett_op_e op, output logic [MASK_W-1:0] mask,
                            output logic [TIMEOUT_W-1:0] tmo);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    tmo  = $urandom;
    mask = MASK_W'($urandom_range(0, 255));
    if (pick < 45) begin
      op = OP_TICK;
    end else if (pick < 70) begin
      op = OP_ARM;
      pick = $urandom_range(0, 99);
      if (pick < 75)      mask = 8'h01 << $urandom_range(0, 7);
      else if (pick < 85) mask = '0;
      pick = $urandom_range(0, 99);
      if (pick < 70)      tmo = $urandom_range(1, 12);
      else if (pick < 80) tmo = '0;
      else if (pick < 90) tmo = $urandom_range(13, 60);
    end else begin
      op = (pick < 85) ? OP_SET : OP_CLEAR;
      if ($urandom_range(0, 1) == 0) mask = 8'h01 << $urandom_range(0, 7);
    end
  endtask

  initial begin
    ett_op_e              op;
    logic [MASK_W-1:0]    mask;
    logic [TIMEOUT_W-1:0] tmo;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle timers, extremes, bad arms, overlapping expiries
    issue(OP_TICK,  8'h00, 32'h0000_0000);
    issue(OP_SET,   8'hFF, 32'hFFFF_FFFF);
    issue(OP_CLEAR, 8'h00, 32'h0000_0000);
    issue(OP_CLEAR, 8'hFF, 32'h0000_0000);
    issue(OP_ARM,   8'h01, 32'h0000_0001);
    issue(OP_TICK,  8'h00, 32'h0000_0000);
    issue(OP_ARM,   8'h80, 32'h0000_0003);
    issue(OP_ARM,   8'h01, 32'hFFFF_FFFF);
    issue(OP_ARM,   8'h03, 32'h0000_0005);
    issue(OP_ARM,   8'h00, 32'h0000_0005);
    issue(OP_ARM,   8'h80, 32'h0000_0000);
    issue(OP_TICK,  8'hFF, 32'hFFFF_FFFF);
    issue(OP_TICK,  8'h00, 32'h0000_0000);
    issue(OP_TICK,  8'h00, 32'h0000_0000);
    issue(OP_SET,   8'h01, 32'h0000_0000);
    issue(OP_CLEAR, 8'h80, 32'h0000_0000);
    issue(OP_ARM,   8'h40, 32'h0000_0002);
    issue(OP_ARM,   8'h20, 32'h0000_0002);
    issue(OP_TICK,  8'h00, 32'h0000_0000);
    issue(OP_TICK,  8'h00, 32'h0000_0000);
    issue(OP_SET,   8'hAA, 32'h0000_0000);
    issue(OP_CLEAR, 8'h55, 32'h0000_0000);
    issue(OP_ARM,   8'h10, 32'hAAAA_AAAA);
    issue(OP_ARM,   8'h08, 32'h5555_5555);
    issue(OP_CLEAR, 8'hFF, 32'h0000_0000);
    drain();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 500) rx_hold_reqs++;
      if (i == 1000) drain();
      random_cmd(op, mask, tmo);
      issue(op, mask, tmo);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (sb.outstanding() != 0) $display("%0d results never arrived", sb.outstanding());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
